@@ design/bank_switched_bus_decoder_macros.svh @@
// Assertion macros used by the checker of the bus decoder.
`ifndef BANK_SWITCHED_BUS_DECODER_MACROS_SVH
`define BANK_SWITCHED_BUS_DECODER_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define BSBD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, outside reset.
`define BSBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication checked in the next cycle, in every cycle including reset.
`define BSBD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bsbd_pkg.sv @@
package bsbd_pkg;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int CLK_W    = 8;
   localparam int TS_W     = 4;
   localparam int TARGET_W = 4;
   localparam int WAIT_W   = 8;
   localparam int BANK_W   = 2;

   // Bus operations.
   localparam logic [OP_W-1:0] OP_MEM_RD = 2'd0;
   localparam logic [OP_W-1:0] OP_MEM_WR = 2'd1;
   localparam logic [OP_W-1:0] OP_IO_WR  = 2'd2;
   localparam logic [OP_W-1:0] OP_IO_RD  = 2'd3;

   // Targets.
   localparam logic [TARGET_W-1:0] TGT_RAM    = 4'd0;
   localparam logic [TARGET_W-1:0] TGT_ROM    = 4'd1;
   localparam logic [TARGET_W-1:0] TGT_VRAM   = 4'd2;
   localparam logic [TARGET_W-1:0] TGT_DUMMY  = 4'd3;
   localparam logic [TARGET_W-1:0] TGT_PIO    = 4'd4;
   localparam logic [TARGET_W-1:0] TGT_TIMER  = 4'd5;
   localparam logic [TARGET_W-1:0] TGT_GATE0  = 4'd6;
   localparam logic [TARGET_W-1:0] TGT_STATUS = 4'd7;
   localparam logic [TARGET_W-1:0] TGT_PCG    = 4'd8;
   localparam logic [TARGET_W-1:0] TGT_NONE   = 4'd9;

   // Bank bit positions and reset value.
   localparam int BANK_LOW_BIT  = 0;
   localparam int BANK_HIGH_BIT = 1;
   localparam logic [BANK_W-1:0] BANK_RESET = 2'b11;

   // Bank switch ports (low address byte of an I/O write).
   localparam logic [7:0] PORT_LOW_OFF  = 8'he0;
   localparam logic [7:0] PORT_HIGH_OFF = 8'he1;
   localparam logic [7:0] PORT_LOW_ON   = 8'he2;
   localparam logic [7:0] PORT_HIGH_ON  = 8'he3;
   localparam logic [7:0] PORT_BOTH_ON  = 8'he4;

   // Memory map.
   localparam logic [ADDR_W-1:0] ROM_END    = 16'h1000;
   localparam logic [ADDR_W-1:0] VRAM_BASE  = 16'hd000;
   localparam logic [ADDR_W-1:0] VRAM_LAST  = 16'hdfff;
   localparam logic [ADDR_W-1:0] MMIO_BASE  = 16'he000;
   localparam logic [ADDR_W-1:0] MMIO_LAST  = 16'he00f;
   localparam logic [ADDR_W-1:0] PCG_BASE   = 16'he010;
   localparam logic [ADDR_W-1:0] PCG_LAST   = 16'he012;
   localparam logic [3:0]        SLOT_GATE  = 4'd8;

   // Read values.
   localparam logic [DATA_W-1:0] RD_FLOAT       = 8'hff;
   localparam logic [DATA_W-1:0] STATUS_FIXED   = 8'h7e;
   localparam logic [DATA_W-1:0] STATUS_NOBLANK = 8'h80;

   localparam logic [CLK_W-1:0] BLANK_START_RESET = 8'd160;
   localparam logic [WAIT_W-1:0] WAIT_MAX         = 8'hff;

   // One access as held in the input register.
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
      logic              hblank_flag;
      logic              tempo_flag;
      logic [CLK_W-1:0]  clocks_since_line;
      logic [TS_W-1:0]   cpu_tstates;
   } req_type;

   // One decode result.
   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [ADDR_W-1:0]   offset;
      logic [DATA_W-1:0]   read_data;
      logic [WAIT_W-1:0]   wait_states;
   } rsp_type;

endpackage

@@ design/bsbd_req_if.sv @@
interface bsbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [bsbd_pkg::OP_W-1:0]    operation;
   logic [bsbd_pkg::ADDR_W-1:0]  address;
   logic [bsbd_pkg::DATA_W-1:0]  write_data;
   logic                         hblank_flag;
   logic                         tempo_flag;
   logic [bsbd_pkg::CLK_W-1:0]   clocks_since_line;
   logic [bsbd_pkg::TS_W-1:0]    cpu_tstates;

   modport source (
      output valid, operation, address, write_data, hblank_flag, tempo_flag,
             clocks_since_line, cpu_tstates,
      input  ready
   );

   modport sink (
      input  valid, operation, address, write_data, hblank_flag, tempo_flag,
             clocks_since_line, cpu_tstates,
      output ready
   );
endinterface

@@ design/bsbd_rsp_if.sv @@
interface bsbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsbd_pkg::TARGET_W-1:0] target;
   logic [bsbd_pkg::ADDR_W-1:0]   offset;
   logic [bsbd_pkg::DATA_W-1:0]   read_data;
   logic [bsbd_pkg::WAIT_W-1:0]   wait_states;

   modport source (
      output valid, target, offset, read_data, wait_states,
      input  ready
   );

   modport sink (
      input  valid, target, offset, read_data, wait_states,
      output ready
   );
endinterface

@@ design/bsbd_decode.sv @@
// Address decode of one registered access and next value of the bank bits.
module bsbd_decode (
   input  bsbd_pkg::req_type                  req_i,
   input  logic [bsbd_pkg::BANK_W-1:0]        bank_i,
   input  logic [bsbd_pkg::CLK_W-1:0]         blank_start_i,
   output bsbd_pkg::rsp_type                  rsp_o,
   output logic [bsbd_pkg::BANK_W-1:0]        bank_o
);

   logic                         is_write;
   logic                         low_on;
   logic                         high_on;
   logic [bsbd_pkg::ADDR_W-1:0]  addr;
   logic [3:0]                   slot;
   logic [bsbd_pkg::CLK_W-1:0]   gap;
   logic [bsbd_pkg::CLK_W+1:0]   vram_wait;

   assign addr     = req_i.address;
   assign slot     = addr[3:0];
   assign is_write = (req_i.operation == bsbd_pkg::OP_MEM_WR);
   assign low_on   = bank_i[bsbd_pkg::BANK_LOW_BIT];
   assign high_on  = bank_i[bsbd_pkg::BANK_HIGH_BIT];

   // Video RAM stall: clocks left until blanking, plus the last cycle's t-states and two.
   assign gap       = blank_start_i - req_i.clocks_since_line;
   assign vram_wait = {2'b00, gap} + {6'd0, req_i.cpu_tstates} + 10'd2;

   always_comb begin
      rsp_o.target      = bsbd_pkg::TGT_RAM;
      rsp_o.offset      = addr;
      rsp_o.read_data   = '0;
      rsp_o.wait_states = '0;
      bank_o            = bank_i;

      case (req_i.operation)
         bsbd_pkg::OP_IO_WR: begin
            rsp_o.target = bsbd_pkg::TGT_NONE;
            rsp_o.offset = {8'd0, addr[7:0]};
            case (addr[7:0])
               bsbd_pkg::PORT_LOW_OFF:  bank_o[bsbd_pkg::BANK_LOW_BIT]  = 1'b0;
               bsbd_pkg::PORT_HIGH_OFF: bank_o[bsbd_pkg::BANK_HIGH_BIT] = 1'b0;
               bsbd_pkg::PORT_LOW_ON:   bank_o[bsbd_pkg::BANK_LOW_BIT]  = 1'b1;
               bsbd_pkg::PORT_HIGH_ON:  bank_o[bsbd_pkg::BANK_HIGH_BIT] = 1'b1;
               bsbd_pkg::PORT_BOTH_ON:  bank_o = bsbd_pkg::BANK_RESET;
               default:                 bank_o = bank_i;
            endcase
         end
         bsbd_pkg::OP_IO_RD: begin
            rsp_o.target    = bsbd_pkg::TGT_NONE;
            rsp_o.offset    = {8'd0, addr[7:0]};
            rsp_o.read_data = bsbd_pkg::RD_FLOAT;
         end
         default: begin
            // Memory access: boot ROM, video RAM, mapped I/O, then plain RAM.
            if (low_on && addr < bsbd_pkg::ROM_END) begin
               rsp_o.wait_states = 8'd1;
               rsp_o.target      = is_write ? bsbd_pkg::TGT_DUMMY : bsbd_pkg::TGT_ROM;
            end else if (high_on && addr >= bsbd_pkg::VRAM_BASE
                         && addr <= bsbd_pkg::VRAM_LAST) begin
               rsp_o.target = bsbd_pkg::TGT_VRAM;
               rsp_o.offset = addr - bsbd_pkg::VRAM_BASE;
               if (blank_start_i > req_i.clocks_since_line) begin
                  rsp_o.wait_states = (vram_wait[9:8] != 2'b00) ? bsbd_pkg::WAIT_MAX
                                                                : vram_wait[7:0];
               end
            end else if (high_on && addr >= bsbd_pkg::MMIO_BASE) begin
               if (addr <= bsbd_pkg::MMIO_LAST) begin
                  if (slot[3:2] == 2'b00) begin
                     rsp_o.target = bsbd_pkg::TGT_PIO;
                     rsp_o.offset = {14'd0, addr[1:0]};
                  end else if (slot[3:2] == 2'b01) begin
                     rsp_o.target = bsbd_pkg::TGT_TIMER;
                     rsp_o.offset = {14'd0, addr[1:0]};
                  end else if (slot == bsbd_pkg::SLOT_GATE) begin
                     rsp_o.offset = '0;
                     if (is_write) begin
                        rsp_o.target = bsbd_pkg::TGT_GATE0;
                     end else begin
                        rsp_o.target    = bsbd_pkg::TGT_STATUS;
                        rsp_o.read_data = bsbd_pkg::STATUS_FIXED
                                        | (req_i.hblank_flag ? 8'h00
                                                             : bsbd_pkg::STATUS_NOBLANK)
                                        | {7'd0, req_i.tempo_flag};
                     end
                  end else begin
                     rsp_o.target    = bsbd_pkg::TGT_DUMMY;
                     rsp_o.read_data = is_write ? 8'h00 : bsbd_pkg::RD_FLOAT;
                  end
               end else if (is_write && addr >= bsbd_pkg::PCG_BASE
                            && addr <= bsbd_pkg::PCG_LAST) begin
                  rsp_o.target = bsbd_pkg::TGT_PCG;
                  rsp_o.offset = addr - bsbd_pkg::PCG_BASE;
               end else begin
                  rsp_o.target    = bsbd_pkg::TGT_DUMMY;
                  rsp_o.read_data = is_write ? 8'h00 : bsbd_pkg::RD_FLOAT;
               end
            end
         end
      endcase
   end

endmodule

@@ design/bank_switched_bus_decoder.sv @@
// Bank-switched bus decoder.
// The req_bus channel carries one CPU bus access per transfer (operation, address,
// write data and the display timing levels sampled for it). The rsp_bus channel
// returns one decode result per access: target, offset, read byte and wait count.
// csr_wr_en with csr_wr_data sets the clock at which display blanking starts;
// write it only while no access is in flight.
// An accepted access is captured in the input register, decoded from it and
// moved into the result register, which drives rsp_bus, once that register is
// free or drains; a stalled receiver can hold it in the input register.
// One access is accepted every cycle while the receiver keeps up; the single
// decode stage between the two registers sets that rate, and an access that
// switches banks affects the very next one.
// Reset clears both registers' valid flags, turns both monitor banks on and sets
// the blanking start clock to 160.
// When the receiver stalls, the result holds steady, the input register still
// takes one more access, and then req_bus.ready drops until the result is taken.
module bank_switched_bus_decoder (
   input  logic                         clock,
   input  logic                         reset,
   bsbd_req_if.sink                     req_bus,
   bsbd_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [bsbd_pkg::CLK_W-1:0]   csr_wr_data
);

   bsbd_pkg::req_type                req_q_ff;
   logic                             req_vld_ff;
   bsbd_pkg::rsp_type                rsp_q_ff;
   bsbd_pkg::rsp_type                rsp_q_in;
   logic                             rsp_vld_ff;
   logic [bsbd_pkg::BANK_W-1:0]      bank_ff;
   logic [bsbd_pkg::BANK_W-1:0]      bank_in;
   logic [bsbd_pkg::CLK_W-1:0]       blank_ff;
   logic                             rsp_free;
   logic                             advance;
   logic                             req_take;

   // Pipeline flow: the decode stage moves when the result register is free or drains.
   assign rsp_free      = !rsp_vld_ff || rsp_bus.ready;
   assign advance       = req_vld_ff && rsp_free;
   assign req_bus.ready = !req_vld_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   bsbd_decode u_decode (
      .req_i         (req_q_ff),
      .bank_i        (bank_ff),
      .blank_start_i (blank_ff),
      .rsp_o         (rsp_q_in),
      .bank_o        (bank_in)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         bank_ff    <= bsbd_pkg::BANK_RESET;
         blank_ff   <= bsbd_pkg::BLANK_START_RESET;
      end else begin
         if (req_bus.ready) begin
            req_vld_ff <= req_bus.valid;
         end
         if (rsp_free) begin
            rsp_vld_ff <= req_vld_ff;
         end
         if (advance) begin
            bank_ff <= bank_in;
         end
         if (csr_wr_en) begin
            blank_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_q_ff.operation         <= req_bus.operation;
         req_q_ff.address           <= req_bus.address;
         req_q_ff.hblank_flag       <= req_bus.hblank_flag;
         req_q_ff.tempo_flag        <= req_bus.tempo_flag;
         req_q_ff.clocks_since_line <= req_bus.clocks_since_line;
         req_q_ff.cpu_tstates       <= req_bus.cpu_tstates;
      end
      if (advance) begin
         rsp_q_ff <= rsp_q_in;
      end
   end

   // Result channel.
   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.target      = rsp_q_ff.target;
   assign rsp_bus.offset      = rsp_q_ff.offset;
   assign rsp_bus.read_data   = rsp_q_ff.read_data;
   assign rsp_bus.wait_states = rsp_q_ff.wait_states;

endmodule

@@ design/bsbd_checker.sv @@
`include "bank_switched_bus_decoder_macros.svh"

// Port-level checks of the bus decoder.
module bsbd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bsbd_pkg::TARGET_W-1:0]   rsp_target,
   input logic [bsbd_pkg::ADDR_W-1:0]     rsp_offset,
   input logic [bsbd_pkg::DATA_W-1:0]     rsp_read_data,
   input logic [bsbd_pkg::WAIT_W-1:0]     rsp_wait_states
);

   // No result is shown in the cycle after reset.
   `BSBD_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

   // A stalled result keeps its value.
   `BSBD_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_target) && $stable(rsp_offset) && $stable(rsp_read_data) && $stable(rsp_wait_states), "stalled result changed")

   // Status reads always carry the fixed middle bits and no wait.
   `BSBD_ASSERT_NOW(a_status_bits, clock, reset, rsp_valid && rsp_target == bsbd_pkg::TGT_STATUS, rsp_read_data[6:1] == 6'h3f && rsp_offset == '0 && rsp_wait_states == '0, "bad status byte")

   // Plain RAM accesses never wait and read nothing from the decoder.
   `BSBD_ASSERT_NOW(a_ram_quiet, clock, reset, rsp_valid && rsp_target == bsbd_pkg::TGT_RAM, rsp_wait_states == '0 && rsp_read_data == '0, "RAM access with wait or data")

   // Boot ROM reads take exactly one wait state and stay in the first 4 KB.
   `BSBD_ASSERT_NOW(a_rom_wait, clock, reset, rsp_valid && rsp_target == bsbd_pkg::TGT_ROM, rsp_wait_states == 8'd1 && rsp_offset < bsbd_pkg::ROM_END, "bad boot ROM decode")

endmodule

bind bank_switched_bus_decoder bsbd_checker u_bsbd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_target      (rsp_bus.target),
   .rsp_offset      (rsp_bus.offset),
   .rsp_read_data   (rsp_bus.read_data),
   .rsp_wait_states (rsp_bus.wait_states)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import bsbd_pkg::*;

   // One CPU bus access as offered on the request channel.
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              hbl;
      logic              tempo;
      logic [CLK_W-1:0]  clk;
      logic [TS_W-1:0]   ts;
   } bus_access_type;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE_LEN   = 4;
   localparam int MAX_PRINTED  = 40;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CLK_W-1:0] csr_wr_data;

   bsbd_req_if req_bus ();
   bsbd_rsp_if rsp_bus ();

   bank_switched_bus_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the decoder state and its blanking register.
   logic [BANK_W-1:0] bank_sel;
   logic [CLK_W-1:0]  blank_start;

   rsp_type expected_decodes[$];
   int error_count;
   int cycle_count;
   int hold_left;
   bit src_idle_on;
   bit snk_idle_on;

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Decode one access the way the block should, updating the bank bits.
   function automatic rsp_type decode_access(input bus_access_type a);
      rsp_type r;
      logic [7:0] port;
      logic [3:0] slot;
      logic is_wr;
      int w;
      r.target      = TGT_RAM;
      r.offset      = a.addr;
      r.read_data   = '0;
      r.wait_states = '0;
      port  = a.addr[7:0];
      slot  = a.addr[3:0];
      is_wr = (a.op == OP_MEM_WR);
      if (a.op == OP_IO_WR || a.op == OP_IO_RD) begin
         r.target = TGT_NONE;
         r.offset = {8'h00, port};
         if (a.op == OP_IO_RD) begin
            r.read_data = RD_FLOAT;
         end else begin
            case (port)
               PORT_LOW_OFF:  bank_sel[BANK_LOW_BIT] = 1'b0;
               PORT_HIGH_OFF: bank_sel[BANK_HIGH_BIT] = 1'b0;
               PORT_LOW_ON:   bank_sel[BANK_LOW_BIT] = 1'b1;
               PORT_HIGH_ON:  bank_sel[BANK_HIGH_BIT] = 1'b1;
               PORT_BOTH_ON: begin
                  bank_sel[BANK_LOW_BIT]  = 1'b1;
                  bank_sel[BANK_HIGH_BIT] = 1'b1;
               end
               default: ;
            endcase
         end
      end else if (bank_sel[BANK_LOW_BIT] && a.addr < ROM_END) begin
         // Boot ROM window: writes are dropped but still cost a wait state.
         r.wait_states = 8'd1;
         r.target      = is_wr ? TGT_DUMMY : TGT_ROM;
      end else if (bank_sel[BANK_HIGH_BIT] && a.addr >= VRAM_BASE && a.addr <= VRAM_LAST) begin
         r.target = TGT_VRAM;
         r.offset = a.addr - VRAM_BASE;
         if (blank_start > a.clk) begin
            w = int'(blank_start) - int'(a.clk) + int'(a.ts) + 2;
            r.wait_states = (w > 255) ? WAIT_MAX : 8'(w);
         end
      end else if (bank_sel[BANK_HIGH_BIT] && a.addr >= MMIO_BASE) begin
         if (a.addr <= MMIO_LAST) begin
            if (slot < 4'd4) begin
               r.target = TGT_PIO;
               r.offset = {14'd0, a.addr[1:0]};
            end else if (slot < SLOT_GATE) begin
               r.target = TGT_TIMER;
               r.offset = {14'd0, a.addr[1:0]};
            end else if (slot == SLOT_GATE) begin
               r.offset = '0;
               if (is_wr) begin
                  r.target = TGT_GATE0;
               end else begin
                  r.target    = TGT_STATUS;
                  r.read_data = (a.hbl ? 8'h00 : STATUS_NOBLANK) | {7'd0, a.tempo}
                                | STATUS_FIXED;
               end
            end else begin
               r.target    = TGT_DUMMY;
               r.read_data = is_wr ? 8'h00 : RD_FLOAT;
            end
         end else if (is_wr && a.addr >= PCG_BASE && a.addr <= PCG_LAST) begin
            r.target = TGT_PCG;
            r.offset = a.addr - PCG_BASE;
         end else begin
            r.target    = TGT_DUMMY;
            r.read_data = is_wr ? 8'h00 : RD_FLOAT;
         end
      end
      return r;
   endfunction

   function automatic bus_access_type make_access(input logic [OP_W-1:0] op,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [CLK_W-1:0] clk,
                                                  input logic [TS_W-1:0] ts,
                                                  input logic hbl, input logic tempo);
      bus_access_type a;
      a.op    = op;
      a.addr  = addr;
      a.data  = 8'($urandom);
      a.hbl   = hbl;
      a.tempo = tempo;
      a.clk   = clk;
      a.ts    = ts;
      return a;
   endfunction

   // Random access, weighted toward region edges and the bank switch ports.
   function automatic bus_access_type random_access();
      bus_access_type a;
      int pick;
      logic [ADDR_W-1:0] edges[12];
      edges = '{16'h0000, 16'h0fff, 16'h1000, 16'hcfff, 16'hd000, 16'hdfff,
                16'he000, 16'he00f, 16'he010, 16'he012, 16'he013, 16'hffff};
      pick = $urandom_range(99);
      if (pick < 40) a.op = OP_MEM_RD;
      else if (pick < 75) a.op = OP_MEM_WR;
      else if (pick < 90) a.op = OP_IO_WR;
      else a.op = OP_IO_RD;
      pick = $urandom_range(99);
      if (pick < 15) a.addr = 16'($urandom_range(16'h0fff));
      else if (pick < 35) a.addr = VRAM_BASE + 16'($urandom_range(16'h0fff));
      else if (pick < 55) a.addr = MMIO_BASE + 16'($urandom_range(15));
      else if (pick < 62) a.addr = PCG_BASE + 16'($urandom_range(2));
      else if (pick < 70) a.addr = 16'($urandom_range(16'hffff, 16'he013));
      else if (pick < 80) a.addr = edges[$urandom_range(11)];
      else a.addr = 16'($urandom);
      if (a.op == OP_IO_WR && $urandom_range(99) < 60)
         a.addr[7:0] = PORT_LOW_OFF + 8'($urandom_range(4));
      a.data  = 8'($urandom);
      a.hbl   = 1'($urandom);
      a.tempo = 1'($urandom);
      if ($urandom_range(1) == 0) a.clk = 8'($urandom);
      else a.clk = blank_start + 8'($urandom_range(6)) - 8'd3;
      a.ts = 4'($urandom);
      return a;
   endfunction

   // Offer one access and wait for its transfer, then record its expected decode.
   task automatic send_access(input bus_access_type a);
      while (src_idle_on && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.operation         <= a.op;
      req_bus.address           <= a.addr;
      req_bus.write_data        <= a.data;
      req_bus.hblank_flag       <= a.hbl;
      req_bus.tempo_flag        <= a.tempo;
      req_bus.clocks_since_line <= a.clk;
      req_bus.cpu_tstates       <= a.ts;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_decodes.push_back(decode_access(a));
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_decoder();
      req_bus.valid <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   task automatic set_blank_start(input logic [CLK_W-1:0] value);
      drain_decoder();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      blank_start = value;
   endtask

   // Compare one result transfer against the oldest expectation.
   task automatic check_decode();
      rsp_type want;
      if (expected_decodes.size() == 0) begin
         report_mismatch("result transfer with nothing expected");
      end else begin
         want = expected_decodes.pop_front();
         if (rsp_bus.target !== want.target)
            report_mismatch($sformatf("target got %0d want %0d", rsp_bus.target, want.target));
         if (rsp_bus.offset !== want.offset)
            report_mismatch($sformatf("offset got %h want %h", rsp_bus.offset, want.offset));
         if (rsp_bus.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %h want %h",
                                      rsp_bus.read_data, want.read_data));
         if (rsp_bus.wait_states !== want.wait_states)
            report_mismatch($sformatf("wait_states got %0d want %0d",
                                      rsp_bus.wait_states, want.wait_states));
      end
   endtask

   // Result receiver: checks each transfer, stalls at random or for a long hold.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) check_decode();
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
         end else if (snk_idle_on) begin
            rsp_bus.ready <= ($urandom_range(99) >= 14);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Every part of the memory map at reset settings.
   task automatic test_directed_map();
      send_access(make_access(OP_MEM_RD, 16'h0000, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_WR, 16'h0fff, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'h1000, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'hd000, 8'd0, 4'd15, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_WR, 16'hdfff, 8'd159, 4'd0, 1'b1, 1'b1));
      send_access(make_access(OP_MEM_RD, 16'hd123, 8'd160, 4'd7, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'he000, 8'd255, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_WR, 16'he007, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_WR, 16'he008, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'he008, 8'd0, 4'd0, 1'b0, 1'b1));
      send_access(make_access(OP_MEM_RD, 16'he008, 8'd0, 4'd0, 1'b1, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'he00f, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_WR, 16'he009, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_WR, 16'he010, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'he011, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'he013, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_WR, 16'hffff, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_IO_RD, 16'h12e0, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_IO_WR, 16'h00ff, 8'd0, 4'd0, 1'b0, 1'b0));
   endtask

   // Bank switch ports take effect on the very next access.
   task automatic test_bank_switching();
      send_access(make_access(OP_IO_WR, {8'h5a, PORT_LOW_OFF}, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'h0000, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_IO_WR, {8'ha5, PORT_HIGH_OFF}, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'he008, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_IO_WR, {8'hff, PORT_BOTH_ON}, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'h0000, 8'd0, 4'd0, 1'b0, 1'b0));
      send_access(make_access(OP_MEM_RD, 16'hdfff, 8'd0, 4'd0, 1'b0, 1'b0));
   endtask

   // Blanking register at both ends: saturated wait, and no wait at all.
   task automatic test_blank_extremes();
      set_blank_start(8'd255);
      send_access(make_access(OP_MEM_RD, 16'hd000, 8'd0, 4'd15, 1'b0, 1'b0));
      set_blank_start(8'd0);
      send_access(make_access(OP_MEM_WR, 16'hd000, 8'd0, 4'd15, 1'b0, 1'b0));
   endtask

   task automatic test_random_decode(input int count);
      for (int i = 0; i < count; i++) send_access(random_access());
   endtask

   // Back-to-back traffic with neither side idling.
   task automatic test_no_idle_stretch(input int count);
      drain_decoder();
      src_idle_on = 1'b0;
      snk_idle_on = 1'b0;
      test_random_decode(count);
      src_idle_on = 1'b1;
      snk_idle_on = 1'b1;
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_receiver_hold(input int count);
      drain_decoder();
      src_idle_on = 1'b0;
      hold_left <= HOLD_CYCLES;
      test_random_decode(count);
      src_idle_on = 1'b1;
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_MEM_RD;
      req_bus.address   = '0;
      req_bus.write_data        = '0;
      req_bus.hblank_flag       = 1'b0;
      req_bus.tempo_flag        = 1'b0;
      req_bus.clocks_since_line = '0;
      req_bus.cpu_tstates       = '0;
      rsp_bus.ready     = 1'b0;
      bank_sel          = BANK_RESET;
      blank_start       = BLANK_START_RESET;
      error_count       = 0;
      cycle_count       = 0;
      hold_left         = 0;
      src_idle_on       = 1'b1;
      snk_idle_on       = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_map();
      test_bank_switching();
      test_blank_extremes();

      set_blank_start(8'd255);
      test_random_decode(220);
      set_blank_start(8'd0);
      test_random_decode(220);
      set_blank_start(8'($urandom_range(254, 1)));
      test_random_decode(220);
      set_blank_start(BLANK_START_RESET);
      test_random_decode(220);
      test_no_idle_stretch(160);
      test_receiver_hold(60);
      set_blank_start(8'($urandom));
      test_random_decode(200);

      drain_decoder();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
